@@ src/ptb_pkg.sv @@
// Shared types, constants and the per-entry timer update function for the timer bank.
// No dependencies.
`timescale 1ns / 1ps
package ptb_pkg;

  localparam int TimersPerKindDefault = 16;
  localparam int KindCount = 5;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_TON  = 3'd0,
    KIND_TOF  = 3'd1,
    KIND_TP   = 3'd2,
    KIND_RTON = 3'd3,
    KIND_RTOF = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TICK_READ,
    ST_TICK_WRITE
  } state_t;

  // Flag bits of one entry.
  localparam int FL_EN = 0;
  localparam int FL_IN = 1;
  localparam int FL_PREV = 2;
  localparam int FL_TIMING = 3;
  localparam int FL_Q = 4;

  typedef struct packed {
    logic [4:0]  flags;
    logic [31:0] preset;
    logic [31:0] start;
    logic [31:0] elapsed;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the input item
    logic rd_item;     // read the addressed entry
    logic wr_item;     // update and write back the addressed entry
    logic tick_clear;  // reset the sweep pointer
    logic tick_rd;     // read the entry at the sweep pointer
    logic tick_wr;     // update and write it back, advance the pointer
    logic respond;     // present a result
  } ctrl_t;

  typedef struct packed {
    logic item_valid;
    logic tick_last;
  } status_t;

  function automatic entry_t update_entry(input logic [2:0] kind, input entry_t e,
                                          input logic [31:0] now);
    entry_t r;
    logic   in_l;
    logic   rise;
    logic   fall;
    logic [31:0] d;
    logic [31:0] acc;
    r = e;
    in_l = e.flags[FL_IN];
    rise = in_l & ~e.flags[FL_PREV];
    fall = ~in_l & e.flags[FL_PREV];
    d = now - e.start;
    acc = e.elapsed + d;
    if (!e.flags[FL_EN]) begin
      if (kind <= KIND_TP) begin
        r.flags[FL_Q] = 1'b0;
        r.elapsed = '0;
      end
    end else if (kind <= KIND_TP && e.preset == '0) begin
      r.flags[FL_Q] = 1'b0;
      r.elapsed = '0;
    end else begin
      unique case (kind)
        KIND_TON: begin
          if (in_l) begin
            if (rise) begin
              r.start = now;
              r.flags[FL_TIMING] = 1'b1;
              d = '0;
            end
            if (r.flags[FL_TIMING]) begin
              r.elapsed = d;
              if (d >= e.preset) begin
                r.flags[FL_Q] = 1'b1;
                r.flags[FL_TIMING] = 1'b0;
              end
            end
          end else begin
            r.flags[FL_Q] = 1'b0;
            r.flags[FL_TIMING] = 1'b0;
            r.elapsed = '0;
          end
        end
        KIND_TOF: begin
          if (in_l) begin
            r.flags[FL_Q] = 1'b1;
            r.flags[FL_TIMING] = 1'b0;
            r.elapsed = '0;
          end else begin
            if (fall) begin
              r.start = now;
              r.flags[FL_TIMING] = 1'b1;
              d = '0;
            end
            if (r.flags[FL_TIMING]) begin
              r.elapsed = d;
              if (d >= e.preset) begin
                r.flags[FL_Q] = 1'b0;
                r.flags[FL_TIMING] = 1'b0;
              end else begin
                r.flags[FL_Q] = 1'b1;
              end
            end
          end
        end
        KIND_TP: begin
          if (rise) begin
            r.start = now;
            r.flags[FL_TIMING] = 1'b1;
            r.flags[FL_Q] = 1'b1;
            d = '0;
          end
          if (r.flags[FL_TIMING]) begin
            r.elapsed = d;
            if (d >= e.preset) begin
              r.flags[FL_Q] = 1'b0;
              r.flags[FL_TIMING] = 1'b0;
            end
          end
        end
        KIND_RTON: begin
          if (in_l) begin
            if (rise) begin
              r.flags[FL_TIMING] = 1'b1;
              acc = e.elapsed;
            end
            if (r.flags[FL_TIMING]) begin
              r.elapsed = acc;
              r.start = now;
            end
            if (r.elapsed >= e.preset) begin
              r.flags[FL_Q] = 1'b1;
              r.flags[FL_TIMING] = 1'b0;
            end
          end
        end
        default: begin
          if (fall) begin
            r.flags[FL_TIMING] = 1'b1;
            acc = e.elapsed;
          end
          if (r.flags[FL_TIMING]) begin
            r.elapsed = acc;
            r.start = now;
            if (acc >= e.preset) begin
              r.flags[FL_Q] = 1'b0;
              r.flags[FL_TIMING] = 1'b0;
            end else begin
              r.flags[FL_Q] = 1'b1;
            end
          end
          if (in_l) begin
            r.flags[FL_Q] = 1'b1;
            r.flags[FL_TIMING] = 1'b0;
            r.elapsed = '0;
          end
        end
      endcase
      r.flags[FL_PREV] = in_l;
    end
    return r;
  endfunction

endpackage

@@ src/ptb_ctrl.sv @@
// Controller state machine of the timer bank: sequences set, query and tick sweeps.
// Depends on ptb_pkg.
`timescale 1ns / 1ps
module ptb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  ptb_pkg::status_t  status,
  output ptb_pkg::ctrl_t    ctrl,
  output logic              busy
);
  import ptb_pkg::*;

  state_t state;
  state_t state_next;
  func_t  func_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      func_r <= FUNC_NONE;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) func_r <= func_t'(func);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          priority if (func_t'(func) == FUNC_TICK) state_next = ST_TICK_READ;
          else if (func_t'(func) == FUNC_NONE) state_next = ST_IDLE;
          else state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_TICK_READ: state_next = ST_TICK_WRITE;
      ST_TICK_WRITE: state_next = status.tick_last ? ST_IDLE : ST_TICK_READ;
      default: state_next = ST_IDLE;
    endcase
  end

  // A set writes back and captures its result in the same cycle.
  always_comb begin
    ctrl = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        ctrl.load_item = start;
        ctrl.tick_clear = 1'b1;
        ctrl.rd_item = start;
      end
      ST_READ: begin
        ctrl.wr_item = (func_r == FUNC_SET) && status.item_valid;
        ctrl.respond = 1'b1;
      end
      ST_TICK_READ: ctrl.tick_rd = 1'b1;
      ST_TICK_WRITE: ctrl.tick_wr = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ src/ptb_datapath.sv @@
// Datapath of the timer bank: entry memory, item registers, update logic and result register.
// Depends on ptb_pkg.
`timescale 1ns / 1ps
module ptb_datapath #(
  parameter int TimersPerKind = ptb_pkg::TimersPerKindDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  ptb_pkg::ctrl_t    ctrl,
  input  logic [2:0]        timer_kind,
  input  logic [7:0]        timer_id,
  input  logic              in_level,
  input  logic [31:0]       preset_val,
  input  logic [31:0]       time_now_ms,
  output ptb_pkg::status_t  status,
  output logic              done,
  output logic              q,
  output logic [31:0]       elapsed_ms
);
  import ptb_pkg::*;

  localparam int Slots = KindCount * TimersPerKind;
  localparam int SlotW = $clog2(Slots + 1);
  localparam int IdW = $clog2(TimersPerKind + 1);
  localparam int KindCntW = 3;

  // Reset clears only the written bits; a slot whose written bit is clear
  // reads as an all-zero entry.
  logic [4:0]  flags_mem [Slots];
  logic [Slots-1:0] written;
  logic [31:0] preset_mem [Slots];
  logic [31:0] start_mem [Slots];
  logic [31:0] elapsed_mem [Slots];

  logic [2:0]  kind_r;
  logic        lvl_r;
  logic [31:0] preset_r;
  logic [31:0] now_r;
  logic        valid_r;
  logic [SlotW-1:0] slot_r;
  logic [SlotW-1:0] sweep_slot;
  logic [IdW-1:0]   sweep_id;
  logic [KindCntW-1:0] sweep_kind;

  entry_t rd_entry;
  entry_t cur;
  entry_t upd;
  logic [SlotW-1:0] rd_slot;
  logic [SlotW-1:0] wr_slot;
  logic [2:0]  upd_kind;
  logic        rd_written;
  logic        item_valid;
  logic [SlotW-1:0] item_slot;

  assign item_valid = (timer_kind < 3'(KindCount)) &&
                      ({1'b0, timer_id} < 9'(TimersPerKind));
  assign item_slot = item_valid ?
      SlotW'(32'(timer_kind) * 32'(TimersPerKind) + 32'(timer_id)) : '0;

  assign rd_slot = ctrl.rd_item ? item_slot : sweep_slot;

  // Registered read of the entry memory.
  always_ff @(posedge clk) begin
    rd_entry.flags <= flags_mem[rd_slot[SlotW-1:0]];
    rd_entry.preset <= preset_mem[rd_slot];
    rd_entry.start <= start_mem[rd_slot];
    rd_entry.elapsed <= elapsed_mem[rd_slot];
    rd_written <= written[rd_slot];
  end

  always_comb begin
    cur = rd_entry;
    if (!rd_written) cur = '0;
    if (ctrl.wr_item) begin
      cur.flags[FL_EN] = 1'b1;
      cur.flags[FL_IN] = lvl_r;
      cur.preset = preset_r;
    end
  end

  assign upd_kind = ctrl.wr_item ? kind_r : 3'(sweep_kind);
  assign upd = update_entry(upd_kind, cur, now_r);
  assign wr_slot = ctrl.wr_item ? slot_r : sweep_slot;

  always_ff @(posedge clk) begin
    if (ctrl.wr_item || ctrl.tick_wr) begin
      flags_mem[wr_slot] <= upd.flags;
      preset_mem[wr_slot] <= upd.preset;
      start_mem[wr_slot] <= upd.start;
      elapsed_mem[wr_slot] <= upd.elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) written <= '0;
    else if (ctrl.wr_item || ctrl.tick_wr) written[wr_slot] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      kind_r <= timer_kind;
      lvl_r <= in_level;
      preset_r <= preset_val;
      now_r <= time_now_ms;
      valid_r <= item_valid;
      slot_r <= item_slot;
    end
  end

  // Sweep pointer walks slots in memory order; the order of a tick does not
  // matter since every slot updates independently.
  always_ff @(posedge clk) begin
    if (rst || ctrl.tick_clear) begin
      sweep_slot <= '0;
      sweep_id <= '0;
      sweep_kind <= '0;
    end else if (ctrl.tick_wr) begin
      sweep_slot <= sweep_slot + 1'b1;
      if (sweep_id == IdW'(TimersPerKind - 1)) begin
        sweep_id <= '0;
        sweep_kind <= sweep_kind + 1'b1;
      end else begin
        sweep_id <= sweep_id + 1'b1;
      end
    end
  end

  assign status.item_valid = valid_r;
  assign status.tick_last = (sweep_slot == SlotW'(Slots - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      if (!valid_r) begin
        q <= 1'b0;
        elapsed_ms <= '0;
      end else if (ctrl.wr_item) begin
        q <= upd.flags[FL_Q];
        elapsed_ms <= upd.elapsed;
      end else begin
        q <= cur.flags[FL_Q];
        elapsed_ms <= cur.elapsed;
      end
    end
  end

endmodule

@@ src/plc_timer_bank.sv @@
// Top level of the PLC timer bank: ties the controller to the datapath.
// Depends on ptb_pkg, ptb_ctrl and ptb_datapath.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low. The accepting edge
// reads the addressed entry; a set or a query then holds busy for one cycle, in
// which a set of a valid item updates and writes back the entry. The result then
// shows on q and elapsed_ms and is held until the next result, with done high
// for one cycle, in the same cycle as the result first shows. The receiver
// cannot stall it. A tick sweeps all 5*TIMERS_PER_KIND entries with one read and
// one write-back each, holding busy through alternating read and write-back
// states, and gives no result. Reset marks all entries unwritten at once, so each reads as all zero.
module plc_timer_bank #(
  parameter int TIMERS_PER_KIND = ptb_pkg::TimersPerKindDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [2:0]  timer_kind,
  input  logic [7:0]  timer_id,
  input  logic        in_level,
  input  logic [31:0] preset_val,
  input  logic [31:0] time_now_ms,
  output logic        done,
  output logic        q,
  output logic [31:0] elapsed_ms
);
  import ptb_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  ptb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ptb_datapath #(
    .TimersPerKind (TIMERS_PER_KIND)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .timer_kind  (timer_kind),
    .timer_id    (timer_id),
    .in_level    (in_level),
    .preset_val  (preset_val),
    .time_now_ms (time_now_ms),
    .status      (status),
    .done        (done),
    .q           (q),
    .elapsed_ms  (elapsed_ms)
  );

endmodule
